@@ sv/recursive_mutex_wait_queue_unit_macros.svh @@
`ifndef RECURSIVE_MUTEX_WAIT_QUEUE_UNIT_MACROS_SVH
`define RECURSIVE_MUTEX_WAIT_QUEUE_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define RMWQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define RMWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rmwq_pkg.sv @@
`timescale 1ns / 1ps

package rmwq_pkg;

   // Default sizes
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TASK_BITS_DEF   = 8;
   localparam int MAX_NEST_DEF    = 255;

   // Fixed beat field widths
   localparam int TASK_FIELD_W = 8;
   localparam int NEST_FIELD_W = 8;

   // Request opcodes
   localparam logic OP_LOCK   = 1'b0;
   localparam logic OP_UNLOCK = 1'b1;

   typedef enum logic [2:0] {
      ST_ACQUIRED      = 3'd0,
      ST_REENTERED     = 3'd1,
      ST_BLOCKED       = 3'd2,
      ST_RELEASED_ONE  = 3'd3,
      ST_RELEASED_ALL  = 3'd4,
      ST_NOT_HELD      = 3'd5,
      ST_QUEUE_FULL    = 3'd6,
      ST_NEST_OVERFLOW = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_WAKE = 2'b10
   } state_type;

   typedef struct packed {
      logic                    op;
      logic [TASK_FIELD_W-1:0] task_id;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic                    wake_valid;
      logic [TASK_FIELD_W-1:0] wake_task;
      logic [NEST_FIELD_W-1:0] nest_depth;
   } rsp_type;

   // Outcome of one request, from the lock control to the top level
   typedef struct packed {
      status_type              status;
      logic                    push;
      logic                    pop;
      logic [NEST_FIELD_W-1:0] nest_depth;
   } decision_type;

endpackage

@@ sv/rmwq_ram.sv @@
`timescale 1ns / 1ps

module rmwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rmwq_ctrl.sv @@
`timescale 1ns / 1ps

module rmwq_ctrl
   import rmwq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TASK_BITS   = TASK_BITS_DEF,
   parameter int MAX_NEST    = MAX_NEST_DEF,
   localparam int TASK_W = (TASK_BITS < TASK_FIELD_W) ? TASK_BITS : TASK_FIELD_W,
   localparam int PTR_W  = $clog2(QUEUE_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_type           req,
   output decision_type      dec,
   output logic              wr_en,
   output logic [PTR_W-1:0]  wr_addr,
   output logic [TASK_W-1:0] wr_data,
   output logic              rd_en,
   output logic [PTR_W-1:0]  rd_addr
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int NEST_W = $clog2(MAX_NEST + 1);

   logic              held_ff,   held_in;
   logic [TASK_W-1:0] holder_ff, holder_in;
   logic [NEST_W-1:0] nest_ff,   nest_in;
   logic [PTR_W-1:0]  head_ff,   head_in;
   logic [PTR_W-1:0]  tail_ff,   tail_in;
   logic [FILL_W-1:0] fill_ff,   fill_in;
   logic [TASK_W-1:0] task_id;
   logic              is_holder;

   // Decide the outcome and the next lock and queue state
   always_comb begin
      task_id   = req.task_id[TASK_W-1:0];
      is_holder = held_ff && (holder_ff == task_id);
      held_in   = held_ff;
      holder_in = holder_ff;
      nest_in   = nest_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      dec       = '0;
      dec.status = ST_NOT_HELD;
      unique case (req.op)
         OP_LOCK: begin
            priority if (is_holder) begin
               if (nest_ff == NEST_W'(MAX_NEST)) begin
                  dec.status = ST_NEST_OVERFLOW;
               end else begin
                  nest_in    = nest_ff + NEST_W'(1);
                  dec.status = ST_REENTERED;
               end
            end else if (!held_ff) begin
               held_in    = 1'b1;
               holder_in  = task_id;
               nest_in    = NEST_W'(1);
               dec.status = ST_ACQUIRED;
            end else if (fill_ff == FILL_W'(QUEUE_DEPTH)) begin
               dec.status = ST_QUEUE_FULL;
            end else begin
               dec.push   = 1'b1;
               tail_in    = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
               fill_in    = fill_ff + FILL_W'(1);
               dec.status = ST_BLOCKED;
            end
         end
         OP_UNLOCK: begin
            priority if (!is_holder) begin
               dec.status = ST_NOT_HELD;
            end else if (nest_ff > NEST_W'(1)) begin
               nest_in    = nest_ff - NEST_W'(1);
               dec.status = ST_RELEASED_ONE;
            end else begin
               held_in    = 1'b0;
               holder_in  = '0;
               nest_in    = '0;
               dec.status = ST_RELEASED_ALL;
               if (fill_ff != '0) begin
                  dec.pop = 1'b1;
                  head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
                  fill_in = fill_ff - FILL_W'(1);
               end
            end
         end
      endcase
      dec.nest_depth = NEST_FIELD_W'(nest_in);
   end

   // Drive the waiter memory: push at tail, pop at head
   assign wr_en   = accept && dec.push;
   assign wr_addr = tail_ff;
   assign wr_data = task_id;
   assign rd_en   = accept && dec.pop;
   assign rd_addr = head_ff;

   // Commit state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         holder_ff <= '0;
         nest_ff   <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         fill_ff   <= '0;
      end else if (accept) begin
         held_ff   <= held_in;
         holder_ff <= holder_in;
         nest_ff   <= nest_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

@@ sv/recursive_mutex_wait_queue_unit.sv @@
// Result: the result beat is registered in the cycle after the request is accepted,
// or after the WAKE state's waiter memory read when a full release wakes a waiter.
// Throughput: 1 request per cycle unless rsp_stall holds a result; WAKE stalls requests.
// Reset: synchronous, active high; clears the mutex, the queue pointers, the
// sequencer and the result valid flag. The result payload and the waiter memory
// are not cleared; only written entries are read.
`timescale 1ns / 1ps

`include "recursive_mutex_wait_queue_unit_macros.svh"

module recursive_mutex_wait_queue_unit
   import rmwq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TASK_BITS   = TASK_BITS_DEF,
   parameter int MAX_NEST    = MAX_NEST_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int TASK_W = (TASK_BITS < TASK_FIELD_W) ? TASK_BITS : TASK_FIELD_W;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              accept;
   decision_type      dec;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [TASK_W-1:0] wr_data;
   logic              rd_en;
   logic [PTR_W-1:0]  rd_addr;
   logic [TASK_W-1:0] rd_data;

   // Take a beat when idle and the result register is free or draining
   assign req_stall = (state_ff != STATE_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   rmwq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TASK_BITS   (TASK_BITS),
      .MAX_NEST    (MAX_NEST)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .dec     (dec),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr)
   );

   rmwq_ram #(
      .WIDTH (TASK_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_waiters (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequence the result: direct, or after the waiter read
   always_comb begin
      state_in     = state_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_data_in.status     = dec.status;
               rsp_data_in.wake_valid = dec.pop;
               rsp_data_in.wake_task  = '0;
               rsp_data_in.nest_depth = dec.nest_depth;
               if (dec.pop) begin
                  state_in = STATE_WAKE;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         STATE_WAKE: begin
            rsp_data_in.wake_task = TASK_FIELD_W'(rd_data);
            rsp_valid_in          = 1'b1;
            state_in              = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // Hold control under reset; payload needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RMWQ_ASSERT_NEXT(a_wake_one_cycle, state_ff == STATE_WAKE, state_ff == STATE_IDLE && rsp_valid_ff, "wake read did not finish in one cycle")
   `RMWQ_ASSERT_NEXT(a_pop_enters_wake, accept && dec.pop, state_ff == STATE_WAKE, "pop did not start the waiter read")
   `RMWQ_ASSERT_NOW(a_wake_on_release, rsp_valid_ff && rsp_data_ff.wake_valid, rsp_data_ff.status == ST_RELEASED_ALL, "wake reported without a full release")
   `RMWQ_ASSERT_NOW(a_acquire_depth, rsp_valid_ff && rsp_data_ff.status == ST_ACQUIRED, rsp_data_ff.nest_depth == NEST_FIELD_W'(1), "acquire with nesting other than one")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

import rmwq_pkg::*;

// Predicts the mutex and its wait queue, and holds the results still owed by the block
class mutex_scoreboard;
   localparam logic [TASK_FIELD_W-1:0] TASK_MASK = TASK_FIELD_W'((1 << TASK_BITS_DEF) - 1);

   bit                      held;
   logic [TASK_FIELD_W-1:0] holder;
   int                      nest;
   logic [TASK_FIELD_W-1:0] waiters[$];
   logic [TASK_FIELD_W-1:0] woken[$];
   rsp_type                 pending_results[$];
   int                      errors;

   function new();
      held   = 1'b0;
      holder = '0;
      nest   = 0;
      errors = 0;
   endfunction

   // Advance the mutex by one accepted request beat and queue the result it owes
   function void note_request(req_type r);
      rsp_type                 e;
      logic [TASK_FIELD_W-1:0] id;
      id = r.task_id & TASK_MASK;
      e = '0;
      if (r.op == OP_LOCK) begin
         if (held && holder == id) begin
            if (nest >= MAX_NEST_DEF) begin
               e.status = ST_NEST_OVERFLOW;
            end else begin
               nest++;
               e.status = ST_REENTERED;
            end
         end else if (!held) begin
            held     = 1'b1;
            holder   = id;
            nest     = 1;
            e.status = ST_ACQUIRED;
         end else if (waiters.size() >= QUEUE_DEPTH_DEF) begin
            e.status = ST_QUEUE_FULL;
         end else begin
            waiters.push_back(id);
            e.status = ST_BLOCKED;
         end
      end else begin
         if (!held || holder != id) begin
            e.status = ST_NOT_HELD;
         end else if (nest > 1) begin
            nest--;
            e.status = ST_RELEASED_ONE;
         end else begin
            held     = 1'b0;
            holder   = '0;
            nest     = 0;
            e.status = ST_RELEASED_ALL;
            // pop the oldest waiter as the wake beat
            if (waiters.size() > 0) begin
               e.wake_valid = 1'b1;
               e.wake_task  = waiters.pop_front();
               woken.push_back(e.wake_task);
            end
         end
      end
      e.nest_depth = nest[NEST_FIELD_W-1:0];
      pending_results.push_back(e);
   endfunction

   // Compare one result beat field by field with the oldest one owed
   function void check_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected result beat: status %0d wake %0b task %02h depth %0d",
                     got.status, got.wake_valid, got.wake_task, got.nest_depth);
         return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.wake_valid !== want.wake_valid ||
          got.wake_task !== want.wake_task || got.nest_depth !== want.nest_depth) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp status %0d wake %0b task %02h depth %0d, got %0d %0b %02h %0d",
                     want.status, want.wake_valid, want.wake_task, want.nest_depth,
                     got.status, got.wake_valid, got.wake_task, got.nest_depth);
      end
   endfunction

   function int outstanding();
      return pending_results.size();
   endfunction

   function bit clean();
      return errors == 0 && pending_results.size() == 0;
   endfunction
endclass

module testbench;

   localparam int CLOCK_HALF   = 2;
   localparam int LIMIT_CYCLES = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 4;
   localparam int POOL_SIZE    = 5;
   localparam int PHASE_ITEMS  = 300;
   localparam int PHASES       = 5;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   mutex_scoreboard         sb;
   int                      cycle_count   = 0;
   int                      tx_idle_pct   = 0;
   int                      rx_idle_pct   = 0;
   bit                      long_hold_req = 1'b0;
   logic [TASK_FIELD_W-1:0] task_pool[POOL_SIZE];

   recursive_mutex_wait_queue_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_data);
   end

   // Stall the result channel in random bursts, or for one long stretch on request
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && $urandom_range(0, 99) < rx_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type mk_request(logic op, logic [TASK_FIELD_W-1:0] id);
      req_type r;
      r.op      = op;
      r.task_id = id;
      return r;
   endfunction

   // Hold one request beat until accepted, note it, then maybe leave a gap
   task automatic issue(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every owed result, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic void refresh_pool();
      int roll;
      foreach (task_pool[k]) begin
         roll = $urandom_range(0, 7);
         task_pool[k] = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      end
   endfunction

   // Mostly a lock and unlock protocol over the task pool ids, some noise
   function automatic req_type pick_request();
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r    = mk_request(OP_LOCK, task_pool[$urandom_range(0, POOL_SIZE - 1)]);
      if (roll < 12) begin
         r.op      = 1'($urandom_range(0, 1));
         r.task_id = 8'($urandom_range(0, 255));
      end else if (roll < 16) begin
         // unlock by some task that is likely not the holder
         r.op = OP_UNLOCK;
      end else if (sb.woken.size() > 0 && roll < 60) begin
         r.task_id = sb.woken.pop_front();
      end else if (sb.held && roll < 48) begin
         r.op      = OP_UNLOCK;
         r.task_id = sb.holder;
      end else if (sb.held && roll < 62) begin
         r.task_id = sb.holder;
      end
      return r;
   endfunction

   // Nest one holder up to the limit and past it, then unwind completely
   task automatic run_deep_nesting();
      logic [TASK_FIELD_W-1:0] id;
      int                      n;
      if (!sb.held)
         issue(mk_request(OP_LOCK, task_pool[0]));
      id = sb.holder;
      n  = MAX_NEST_DEF - sb.nest + 2;
      repeat (n) issue(mk_request(OP_LOCK, id));
      while (sb.held && sb.holder == id)
         issue(mk_request(OP_UNLOCK, id));
   endtask

   initial begin : stimulus
      int deep_at;
      sb = new();
      refresh_pool();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: free unlock, acquire, reentry, foreign unlock, fill queue, overflow it, release with wake
      tx_idle_pct = 20;
      rx_idle_pct = 20;
      issue(mk_request(OP_UNLOCK, 8'h00));
      issue(mk_request(OP_LOCK, 8'h00));
      issue(mk_request(OP_LOCK, 8'h00));
      issue(mk_request(OP_UNLOCK, 8'hFF));
      issue(mk_request(OP_UNLOCK, 8'h00));
      issue(mk_request(OP_LOCK, 8'hFF));
      issue(mk_request(OP_LOCK, 8'hFF));
      for (int i = 2; i < QUEUE_DEPTH_DEF; i++)
         issue(mk_request(OP_LOCK, {i[3:0], ~i[3:0]}));
      issue(mk_request(OP_LOCK, 8'hA5));
      issue(mk_request(OP_UNLOCK, 8'h00));
      issue(mk_request(OP_LOCK, 8'hFF));
      sb.woken.delete();
      drain_results();

      // Random phases with different idling
      deep_at = $urandom_range(50, PHASE_ITEMS - 50);
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 10; rx_idle_pct = 10; end
            1: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_idle_pct = 0;  long_hold_req = 1'b1; end
            3: begin tx_idle_pct = 40; rx_idle_pct = 5;  end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 150 == 0)
               refresh_pool();
            if (phase == 2 && i == 80) begin
               tx_idle_pct = 30;
               rx_idle_pct = 30;
            end
            if (phase == 1 && i == deep_at)
               run_deep_nesting();
            issue(pick_request());
         end
         if (phase < PHASES - 1)
            drain_results();
      end

      drain_results();
      if (sb.clean())
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/rmwq_pkg.sv
sv/rmwq_ram.sv
sv/rmwq_ctrl.sv
sv/recursive_mutex_wait_queue_unit.sv
sim/testbench.sv
